FILE: sv/rma_pkg.sv
// ----------------------------------------------------------------------------
// Ring moving average package
// Widths, register codes, sequencer states and the divider interface types
// shared by the ring moving average and its serial divider.
// ----------------------------------------------------------------------------
package rma_pkg;

   // Field widths.
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned HELD_W   = 7;
   // Sum of up to 127 signed 32-bit samples.
   localparam int unsigned SUM_W    = SAMPLE_W + HELD_W;
   localparam int unsigned DIV_CNT_W = $clog2(SUM_W);

   // Result channel payload: average, samples held, zero padding to bytes.
   localparam int unsigned RSP_W = ((SAMPLE_W + HELD_W + 7) / 8) * 8;

   // Store depth and window size after reset.
   localparam int unsigned DEF_CAPACITY  = 64;
   localparam int unsigned RESET_WINDOW  = 64;

   // Register file: 32-bit registers on word addresses.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0]  REG_WINDOW_SIZE = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } rma_state_type;

   typedef struct packed {
      logic                     start;
      logic signed [SUM_W-1:0]  dividend;
      logic [HELD_W-1:0]        divisor;
   } rma_div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] quotient;
   } rma_div_rsp_type;

endpackage

FILE: sv/ring_moving_average.sv
// ----------------------------------------------------------------------------
// Ring moving average
// Keeps the most recent samples of a configurable window in a ring store and
// returns the truncated average of the held samples for every input sample.
// ----------------------------------------------------------------------------
// After reset the block first writes zero into every store entry, one entry
// per cycle, and accepts no sample until that sweep is done; register writes
// are taken during that sweep. Each sample is then summed and divided: the
// single read port of the store delivers one entry per cycle to the
// accumulator, and the serial divider produces one quotient bit per cycle
// over the 39-bit sum (skipped when at most one sample is held). One sample
// is worked on at a time; a new sample is taken as soon as the previous
// result sits in the output register, even if the consumer has not yet taken
// it.
module ring_moving_average #(
   parameter int unsigned CAPACITY = rma_pkg::DEF_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rma_pkg::SAMPLE_W-1:0]    req_tdata,   // [31:0] sample
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rma_pkg::RSP_W-1:0]       rsp_tdata,   // [31:0] average,
                                                        // [38:32] samples_held,
                                                        // [39] zero
   // Register port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rma_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rma_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rma_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import rma_pkg::*;

   // Store address width, and a compare width that holds both a position
   // plus one and a window size.
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = (AW + 1 > HELD_W) ? AW + 1 : HELD_W;
   // Largest window size the 7-bit register and the store both allow.
   localparam int unsigned SIZE_MAX =
      (CAPACITY < (2 ** HELD_W) - 1) ? CAPACITY : (2 ** HELD_W) - 1;
   localparam logic [HELD_W-1:0] SIZE_LIMIT = HELD_W'(SIZE_MAX);
   localparam logic [HELD_W-1:0] RESET_SIZE =
      HELD_W'((RESET_WINDOW > SIZE_MAX) ? SIZE_MAX : RESET_WINDOW);
   localparam logic [AW-1:0] CLR_LAST = AW'(CAPACITY - 1);

   rma_state_type state_ff, state_in;

   logic [AW-1:0]           clr_ff, clr_in;
   logic [HELD_W-1:0]       size_ff, size_in;
   logic [HELD_W-1:0]       held_ff, held_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [HELD_W-1:0]       idx_ff, idx_in;
   logic                    rd_pend_ff;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic [SAMPLE_W-1:0]     rd_data_ff;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [SAMPLE_W-1:0]     rsp_avg_ff, rsp_avg_in;
   logic [HELD_W-1:0]       rsp_held_ff, rsp_held_in;

   // The ring store. Entries are read one at a time while summing.
   logic [SAMPLE_W-1:0]     sample_store_ff [CAPACITY];

   // Sequencer outputs.
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [SAMPLE_W-1:0]     mem_wdata;
   logic                    rd_en;
   logic                    sum_done;
   logic                    rsp_load;

   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    csr_write;
   logic [HELD_W-1:0]       size_clamped;
   logic [CW-1:0]           pos_inc;
   logic [CW-1:0]           idx_wide;
   logic [AW-1:0]           rd_addr;

   rma_div_req_type         div_req;
   rma_div_rsp_type         div_rsp;

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_tvalid_ff && rsp_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // The sum is complete once every held entry has been read and the last
   // read has been added in.
   assign sum_done = (idx_ff == held_ff) && !rd_pend_ff;

   // ------------------------------------------------------------------------
   // Sequencer: next state.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) state_in = ST_SUM;
         end
         ST_SUM: begin
            // With one sample held the sum is the average; with none it is zero.
            if (sum_done) state_in = (held_ff > HELD_W'(1)) ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            if (div_rsp.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer: outputs.
   // ------------------------------------------------------------------------
   always_comb begin
      req_tready       = 1'b0;
      mem_we           = 1'b0;
      mem_waddr        = pos_ff;
      mem_wdata        = req_tdata;
      rd_en            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = acc_ff;
      div_req.divisor  = held_ff;
      rsp_load         = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_we     = req_xfer;
         end
         ST_SUM: begin
            rd_en         = (idx_ff != held_ff);
            div_req.start = sum_done && (held_ff > HELD_W'(1));
         end
         ST_DIV: begin
         end
         ST_OUT: begin
            rsp_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   rma_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------------------------
   // Window bookkeeping, accumulation and the result register.
   // ------------------------------------------------------------------------
   always_comb begin
      size_clamped = (csr_pwdata[HELD_W-1:0] > SIZE_LIMIT) ? SIZE_LIMIT
                                                           : csr_pwdata[HELD_W-1:0];
      pos_inc  = CW'(pos_ff) + CW'(1);
      idx_wide = CW'(idx_ff);
      rd_addr  = idx_wide[AW-1:0];

      clr_in        = clr_ff + AW'(1);
      size_in       = size_ff;
      held_in       = held_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_held_in   = rsp_held_ff;

      if (csr_write && (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_SIZE)) begin
         // A smaller window drops the excess count and restarts the ring
         // position if it now lies outside. The stored samples are kept.
         size_in = size_clamped;
         if (held_ff > size_clamped) held_in = size_clamped;
         if (CW'(pos_ff) >= CW'(size_clamped)) pos_in = '0;
      end else if (req_xfer) begin
         if (held_ff < size_ff) held_in = held_ff + HELD_W'(1);
         pos_in = (pos_inc >= CW'(size_ff)) ? '0 : pos_inc[AW-1:0];
      end

      if (req_xfer) begin
         idx_in = '0;
         acc_in = '0;
      end else begin
         if (rd_en) idx_in = idx_ff + HELD_W'(1);
         if (rd_pend_ff) begin
            acc_in = acc_ff + {{(SUM_W - SAMPLE_W){rd_data_ff[SAMPLE_W-1]}}, rd_data_ff};
         end
      end

      if (rsp_xfer) rsp_tvalid_in = 1'b0;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_avg_in    = (held_ff > HELD_W'(1)) ? div_rsp.quotient
                                                : acc_ff[SAMPLE_W-1:0];
         rsp_held_in   = held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         size_ff       <= RESET_SIZE;
         held_ff       <= '0;
         pos_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         size_ff       <= size_in;
         held_ff       <= held_in;
         pos_ff        <= pos_in;
         rd_pend_ff    <= rd_en;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_held_ff <= rsp_held_in;
   end

   // Store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) sample_store_ff[mem_waddr] <= mem_wdata;
      rd_data_ff <= sample_store_ff[rd_addr];
   end

   // ------------------------------------------------------------------------
   // Ports.
   // ------------------------------------------------------------------------
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_W - SAMPLE_W - HELD_W){1'b0}}, rsp_held_ff, rsp_avg_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_SIZE) ? CSR_DATA_W'(size_ff)
                                                                   : '0;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_held_within_window: assert property (@(posedge clock) disable iff (reset)
      held_ff <= size_ff)
      else $error("held count exceeds the window size");

   a_pos_within_window: assert property (@(posedge clock) disable iff (reset)
      (CW'(pos_ff) < CW'(size_ff)) || (pos_ff == '0))
      else $error("write position outside the window");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("a second sample was taken while one is in progress");

   a_result_from_output_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result presented outside the output step");

   a_divider_only_when_needed: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (held_ff > HELD_W'(1)) && (state_ff == ST_SUM))
      else $error("division started without more than one held sample");

endmodule

FILE: sv/rma_div.sv
// ----------------------------------------------------------------------------
// Ring moving average serial divider
// Restoring signed division of the window sum by the held count, one quotient
// bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rma_div (
   input  logic                     clock,
   input  logic                     reset,
   input  rma_pkg::rma_div_req_type div_req,
   output rma_pkg::rma_div_rsp_type div_rsp
);
   import rma_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [HELD_W-1:0]    div_ff, div_in;
   logic [HELD_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]     dq_ff, dq_in;

   logic [HELD_W:0]      trial;
   logic [HELD_W:0]      trial_diff;
   logic                 fits;
   logic [SUM_W-1:0]     quot_signed;

   // The dividend magnitude shifts out at the top while quotient bits shift
   // in at the bottom of the same register.
   always_comb begin
      trial      = {rem_ff, dq_ff[SUM_W-1]};
      fits       = trial >= {1'b0, div_ff};
      trial_diff = trial - {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = div_req.dividend[SUM_W-1];
         div_in  = div_req.divisor;
         rem_in  = '0;
         dq_in   = div_req.dividend[SUM_W-1] ? SUM_W'(-div_req.dividend)
                                             : SUM_W'(div_req.dividend);
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[HELD_W-1:0] : trial[HELD_W-1:0];
         dq_in  = {dq_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign quot_signed      = neg_ff ? (~dq_ff + SUM_W'(1)) : dq_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_signed[SAMPLE_W-1:0];

endmodule
